/* src/sbl_pkg.sv */
// shared types, tables and constants of the stack blur line filter
package sbl_pkg;

    // default sizes
    localparam int DEF_MAX_RADIUS = 63;
    localparam int DEF_MAX_LINE   = 4096;

    // fixed field widths
    localparam int RAD_W  = 6;
    localparam int SUM_W  = 20;
    localparam int MUL_W  = 10;
    localparam int SHR_W  = 5;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam int WGT_W  = 7;
    localparam int TAP_W  = 7;

    // job fields sized for the largest parameter values
    localparam int JOB_LW = 17;
    localparam int JOB_RW = 9;

    // reset value of the radius register
    localparam logic [RAD_W-1:0] RADIUS_RESET = 6'd2;

    // reciprocal multiplier by radius
    localparam logic [MUL_W-1:0] MUL_TAB [0:63] = '{
        10'd512, 10'd512, 10'd456, 10'd512, 10'd328, 10'd456, 10'd335, 10'd512,
        10'd405, 10'd328, 10'd271, 10'd456, 10'd388, 10'd335, 10'd292, 10'd512,
        10'd454, 10'd405, 10'd364, 10'd328, 10'd298, 10'd271, 10'd496, 10'd456,
        10'd420, 10'd388, 10'd360, 10'd335, 10'd312, 10'd292, 10'd273, 10'd512,
        10'd482, 10'd454, 10'd428, 10'd405, 10'd383, 10'd364, 10'd345, 10'd328,
        10'd312, 10'd298, 10'd284, 10'd271, 10'd259, 10'd496, 10'd475, 10'd456,
        10'd437, 10'd420, 10'd404, 10'd388, 10'd374, 10'd360, 10'd347, 10'd335,
        10'd323, 10'd312, 10'd302, 10'd292, 10'd282, 10'd273, 10'd265, 10'd512
    };

    // right shift by radius
    localparam logic [SHR_W-1:0] SHR_TAB [0:63] = '{
        5'd9,  5'd11, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15,
        5'd15, 5'd15, 5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd17,
        5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd18, 5'd18,
        5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd19,
        5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19,
        5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd20,
        5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20,
        5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd21
    };

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       out_last;
    } t_out_item;

    // one output to compute
    typedef struct packed {
        logic [JOB_LW-1:0] x;
        logic [JOB_LW-1:0] n;
        logic [JOB_RW-1:0] end_slot;
        logic [RAD_W-1:0]  radius;
        logic              last;
    } t_job;

    localparam int JOB_W = $bits(t_job);

endpackage

/* src/stack_blur_line_filter.sv */
// top level of the stack blur line filter
//
// One stack blur pass over a line of RGBA pixels. Pixels enter on the in
// channel (valid/ready), in_last closes the line; blurred pixels leave on the
// out channel in line order, out_last on the final one. The radius register is
// written on the cfg channel (always ready) and takes effect at the next line.
// For each output the back end makes 2r+1 reads of the single ring read port,
// then a drain, a multiply and a clamp step. A pixel is taken only once the
// job queue is empty and the back end has finished its ring reads, so a new
// pixel waits until the reads for the previous output are done. On the last
// pixel the front issues the remaining jobs, r+1 when the line is longer than r.
// The job for output x is issued when pixel x+r is accepted, or at line end.
// A stalled receiver holds the result in the output register; the back end
// then halts after finishing its current computation and input backs up.
// Synchronous active-low reset empties the queue, clears the line counters and
// sets the radius to 2; ring contents are never read before being written.
module stack_blur_line_filter import sbl_pkg::*; #(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int MAX_LINE   = DEF_MAX_LINE
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [RAD_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out
);
    localparam int RS = 2 * MAX_RADIUS + 1;
    localparam int RW = $clog2(RS);

    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    logic          q_full;
    t_job          push_job;
    logic [JOB_W-1:0] head_bits;
    logic          back_busy;
    logic          we;
    logic [RW-1:0] waddr;
    logic [31:0]   wdata;
    logic [RW-1:0] raddr;
    logic [31:0]   rdata;

    assign o_cfg_ready = 1'b1;

    sbl_front #(.MAX_RADIUS(MAX_RADIUS), .MAX_LINE(MAX_LINE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_q_empty   (q_empty),
        .i_q_full    (q_full),
        .i_back_busy (back_busy),
        .o_push      (q_push),
        .o_job       (push_job),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata)
    );

    sbl_queue #(.WIDTH(JOB_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_job),
        .i_pop   (q_pop),
        .o_data  (head_bits),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sbl_ram #(.WIDTH(32), .DEPTH(RS)) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sbl_back #(.MAX_RADIUS(MAX_RADIUS), .MAX_LINE(MAX_LINE)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (t_job'(head_bits)),
        .o_pop       (q_pop),
        .o_busy      (back_busy),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    // a pixel never overwrites the ring while the back end may still read it
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> (q_empty && !back_busy))
        else $error("pixel accepted while ring reads pending");

    // no job pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (!q_full || q_pop))
        else $error("job queue overflow");

    // blurred colour never exceeds its alpha
    a_alpha_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.out_red <= o_out.out_alpha
                         && o_out.out_green <= o_out.out_alpha
                         && o_out.out_blue <= o_out.out_alpha))
        else $error("colour above alpha");
`endif
endmodule

/* src/sbl_ram.sv */
// generic single write, single read ram with registered read
module sbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 127
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/sbl_queue.sv */
// two-entry job queue between front and back
module sbl_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_head;
    logic             r_tail;
    logic [1:0]       r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_tail <= ~r_tail;
            end
            if (i_pop) begin
                r_head <= ~r_head;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_data  = r_mem[r_head];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);
endmodule

/* src/sbl_front.sv */
// front: takes pixels, writes the ring, issues output jobs and end-of-line flush
module sbl_front import sbl_pkg::*; #(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int MAX_LINE   = DEF_MAX_LINE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [RAD_W-1:0]                    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  t_in_item                            i_in,
    input  logic                                i_q_empty,
    input  logic                                i_q_full,
    input  logic                                i_back_busy,
    output logic                                o_push,
    output t_job                                o_job,
    output logic                                o_we,
    output logic [$clog2(2*MAX_RADIUS+1)-1:0]   o_waddr,
    output logic [31:0]                         o_wdata
);
    localparam int RS = 2 * MAX_RADIUS + 1;
    localparam int RW = $clog2(RS);
    localparam int LW = $clog2(MAX_LINE + 1);

    typedef enum logic {F_IN, F_FLUSH} t_fstate;

    t_fstate          r_state;
    logic [RAD_W-1:0] r_blur_radius;
    logic [RAD_W-1:0] r_line_radius;
    logic [LW-1:0]    r_received;
    logic [LW-1:0]    r_emitted;
    logic [RW-1:0]    r_wpos;
    logic [LW-1:0]    r_fx;
    logic [LW-1:0]    r_fn;

    logic             accept;
    logic [RAD_W-1:0] eff_radius;
    logic [RAD_W-1:0] lr;
    logic [LW-1:0]    em;
    logic [LW-1:0]    n;
    logic             line_end;
    logic [RW-1:0]    n_wpos;
    logic             emit_now;
    logic             flush_push;
    logic             flush_last;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == F_IN) && i_q_empty && !i_back_busy;

    // radius latched at line start
    assign eff_radius = (int'(i_cfg_data) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : i_cfg_data;
    assign lr = (r_received == '0) ? r_blur_radius : r_line_radius;
    assign em = (r_received == '0) ? '0 : r_emitted;
    assign n  = r_received + LW'(1);
    assign line_end = i_in.in_last || (n == LW'(MAX_LINE));
    assign n_wpos = (r_wpos == RW'(RS - 1)) ? '0 : r_wpos + RW'(1);
    assign emit_now = accept && !line_end && ((n - LW'(1)) >= LW'(lr));

    assign flush_push = (r_state == F_FLUSH) && !i_q_full;
    assign flush_last = (r_fx == r_fn - LW'(1));

    // ring write
    assign o_we    = accept;
    assign o_waddr = r_wpos;
    assign o_wdata = {i_in.in_alpha, i_in.in_blue, i_in.in_green, i_in.in_red};

    // job to the queue
    always_comb begin
        o_push = emit_now || flush_push;
        if (r_state == F_FLUSH) begin
            o_job.x        = JOB_LW'(r_fx);
            o_job.n        = JOB_LW'(r_fn);
            o_job.end_slot = JOB_RW'(r_wpos);
            o_job.radius   = r_line_radius;
            o_job.last     = flush_last;
        end else begin
            o_job.x        = JOB_LW'(n - LW'(1) - LW'(lr));
            o_job.n        = JOB_LW'(n);
            o_job.end_slot = JOB_RW'(n_wpos);
            o_job.radius   = lr;
            o_job.last     = 1'b0;
        end
    end

    // radius register, line counters and flush sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= F_IN;
            r_blur_radius <= RADIUS_RESET;
            r_line_radius <= RADIUS_RESET;
            r_received    <= '0;
            r_emitted     <= '0;
            r_wpos        <= '0;
            r_fx          <= '0;
            r_fn          <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_blur_radius <= eff_radius;
            end
            case (r_state)
                F_IN: begin
                    if (accept) begin
                        r_line_radius <= lr;
                        r_wpos        <= n_wpos;
                        if (line_end) begin
                            r_fx       <= em;
                            r_fn       <= n;
                            r_received <= '0;
                            r_emitted  <= '0;
                            r_state    <= F_FLUSH;
                        end else begin
                            r_received <= n;
                            r_emitted  <= emit_now ? em + LW'(1) : em;
                        end
                    end
                end
                F_FLUSH: begin
                    if (flush_push) begin
                        r_fx <= r_fx + LW'(1);
                        if (flush_last) begin
                            r_state <= F_IN;
                        end
                    end
                end
                default: r_state <= F_IN;
            endcase
        end
    end
endmodule

/* src/sbl_back.sv */
// back: walks the window through the ring, scales, clamps and holds the result
module sbl_back import sbl_pkg::*; #(
    parameter int MAX_RADIUS = DEF_MAX_RADIUS,
    parameter int MAX_LINE   = DEF_MAX_LINE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  t_job                                i_job,
    output logic                                o_pop,
    output logic                                o_busy,
    output logic [$clog2(2*MAX_RADIUS+1)-1:0]   o_raddr,
    input  logic [31:0]                         i_rdata,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output t_out_item                           o_out
);
    localparam int RS = 2 * MAX_RADIUS + 1;
    localparam int RW = $clog2(RS);
    localparam int LW = $clog2(MAX_LINE + 1);
    localparam int PW = LW + 2;

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_MUL, S_FIN} t_bstate;

    t_bstate           r_state;
    logic [LW-1:0]     r_x;
    logic [LW-1:0]     r_n;
    logic [RW-1:0]     r_end_slot;
    logic [RAD_W-1:0]  r_radius;
    logic              r_last;
    logic [TAP_W-1:0]  r_tap;
    logic              r_rd_valid;
    logic [WGT_W-1:0]  r_rd_w;
    logic              r_rd_centre;
    logic [SUM_W-1:0]  r_sum [3];
    logic [7:0]        r_alpha;
    logic [PROD_W-1:0] r_prod [3];
    logic              r_out_valid;
    t_out_item         r_out;

    logic signed [PW-1:0] k;
    logic signed [PW-1:0] pos;
    logic [WGT_W-1:0]     abs_k;
    logic [WGT_W-1:0]     weight;
    logic [LW-1:0]        pos_u;
    logic [RW:0]          back_dist;
    logic [RW:0]          slot_raw;
    logic [RW:0]          slot;
    logic [PROD_W-1:0]    scaled [3];
    logic [7:0]           clamped [3];
    logic                 load_out;

    // tap position, clamped to the line
    always_comb begin
        k     = PW'($signed({1'b0, r_tap})) - PW'($signed({1'b0, r_radius}));
        abs_k = (k < 0) ? WGT_W'(-k) : WGT_W'(k);
        weight = WGT_W'(r_radius) + WGT_W'(1) - abs_k;
        pos   = $signed({2'b00, r_x}) + k;
        if (pos < 0) begin
            pos = '0;
        end
        if (pos > $signed({2'b00, r_n - LW'(1)})) begin
            pos = $signed({2'b00, r_n - LW'(1)});
        end
        pos_u     = LW'(pos);
        back_dist = (RW+1)'(r_n - pos_u);
        slot_raw  = {1'b0, r_end_slot} + (RW+1)'(RS) - back_dist;
        slot      = (slot_raw >= (RW+1)'(RS)) ? slot_raw - (RW+1)'(RS) : slot_raw;
    end

    assign o_raddr = RW'(slot);
    assign o_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign o_busy  = (r_state == S_RUN) || (r_state == S_DRAIN);
    assign load_out = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    // shift and clamp to alpha
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            scaled[c]  = r_prod[c] >> SHR_TAB[r_radius];
            clamped[c] = (scaled[c] > PROD_W'(r_alpha)) ? r_alpha : scaled[c][7:0];
        end
    end

    // sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= 1'b0;
            if (r_rd_valid) begin
                for (int c = 0; c < 3; c++) begin
                    r_sum[c] <= r_sum[c] + SUM_W'(i_rdata[8*c +: 8] * r_rd_w);
                end
                if (r_rd_centre) begin
                    r_alpha <= i_rdata[31:24];
                end
            end
            if (r_out_valid && i_out_ready && !load_out) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_x        <= LW'(i_job.x);
                        r_n        <= LW'(i_job.n);
                        r_end_slot <= RW'(i_job.end_slot);
                        r_radius   <= i_job.radius;
                        r_last     <= i_job.last;
                        r_tap      <= '0;
                        for (int c = 0; c < 3; c++) begin
                            r_sum[c] <= '0;
                        end
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rd_valid  <= 1'b1;
                    r_rd_w      <= weight;
                    r_rd_centre <= (r_tap == TAP_W'(r_radius));
                    r_tap       <= r_tap + TAP_W'(1);
                    if (r_tap == TAP_W'({r_radius, 1'b0})) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    for (int c = 0; c < 3; c++) begin
                        r_prod[c] <= PROD_W'(r_sum[c]) * PROD_W'(MUL_TAB[r_radius]);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (load_out) begin
                        r_out_valid     <= 1'b1;
                        r_out.out_red   <= clamped[0];
                        r_out.out_green <= clamped[1];
                        r_out.out_blue  <= clamped[2];
                        r_out.out_alpha <= r_alpha;
                        r_out.out_last  <= r_last;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule
